// ===== rtl/core/ulpbs_pkg.sv =====
// Package for the unconstrained LP bound solver: shared types, codes and
// saturation helpers. No dependencies.
`default_nettype none

package ulpbs_pkg;

	localparam int unsigned ValW = 48;
	localparam int unsigned MagW = 47;
	localparam int unsigned CntW = 17;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [MagW-1:0] MAX47 = {MagW{1'b1}};
	localparam logic signed [ValW-1:0] MAX_S48 = {1'b0, {MagW{1'b1}}};
	localparam logic signed [ValW-1:0] MIN_S48 = {1'b1, {MagW{1'b0}}};

	// Item kinds
	localparam logic OP_ROW    = 1'b0;
	localparam logic OP_COLUMN = 1'b1;

	// Basis status codes
	localparam logic [1:0] BASIS_BASIC = 2'd0;
	localparam logic [1:0] BASIS_LOWER = 2'd1;
	localparam logic [1:0] BASIS_UPPER = 2'd2;
	localparam logic [1:0] BASIS_ZERO  = 2'd3;

	// Model status codes
	localparam logic [1:0] MODEL_OPTIMAL    = 2'd0;
	localparam logic [1:0] MODEL_INFEASIBLE = 2'd1;
	localparam logic [1:0] MODEL_UNBOUNDED  = 2'd2;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_PRIMAL_TOL = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DUAL_TOL   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SENSE      = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_OFFSET     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_INFINITY   = 3'd4;

	typedef struct packed {
		logic [MagW-1:0]        primal_tol;
		logic [MagW-1:0]        dual_tol;
		logic                   maximize;
		logic signed [ValW-1:0] offset;
		logic [MagW-1:0]        infinity;
	} cfg_t;

	typedef struct packed {
		logic                   operation;
		logic signed [ValW-1:0] lower_bound;
		logic signed [ValW-1:0] upper_bound;
		logic signed [ValW-1:0] cost_coefficient;
		logic                   final_item;
	} item_t;

	// Classified item: value, reported dual, status and infeasibilities
	typedef struct packed {
		logic                   is_col;
		logic                   final_item;
		logic signed [ValW-1:0] value;
		logic signed [ValW-1:0] cost;
		logic [1:0]             status;
		logic [MagW-1:0]        pinf;
		logic [MagW-1:0]        dinf;
	} class_t;

	typedef struct packed {
		logic                   valid;
		logic [1:0]             problem_status;
		logic [CntW-1:0]        pcount;
		logic [CntW-1:0]        dcount;
		logic signed [ValW-1:0] objective;
		logic [MagW-1:0]        pmax;
		logic [MagW-1:0]        dmax;
		logic [MagW-1:0]        psum;
		logic [MagW-1:0]        dsum;
	} summary_t;

	// Clamp a 49-bit signed value to [0, 2^47-1]
	function automatic logic [MagW-1:0] clamp_u47(input logic signed [ValW:0] v);
		logic [MagW-1:0] r;
		if (v[ValW])
			r = '0;
		else if (v[ValW-1])
			r = MAX47;
		else
			r = v[MagW-1:0];
		return r;
	endfunction

	// Clamp a 49-bit signed value to the 48-bit signed range
	function automatic logic signed [ValW-1:0] clamp_s48(input logic signed [ValW:0] v);
		logic signed [ValW-1:0] r;
		if (v[ValW] != v[ValW-1])
			r = v[ValW] ? MIN_S48 : MAX_S48;
		else
			r = v[ValW-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ulpbs_classify.sv =====
// Column and row classification: value, status, dual and infeasibilities.
// Combinational; uses ulpbs_pkg.
`default_nettype none

module ulpbs_classify
	import ulpbs_pkg::*;
(
	input  item_t  item,
	input  cfg_t   cfg,
	output class_t cls
);

	logic signed [ValW:0]   lo, up, cst, neg_cost, gap;
	logic signed [ValW:0]   inf_p, inf_n, ptol_p, ptol_n, dtol_p, dtol_n;
	logic signed [ValW:0]   dual_w, ndual;
	logic signed [ValW-1:0] dual;
	logic [MagW-1:0]        adual;
	logic                   lo_minf, lo_pinf, up_pinf, up_minf;

	// Widen operands and thresholds
	always_comb begin
		lo       = {item.lower_bound[ValW-1], item.lower_bound};
		up       = {item.upper_bound[ValW-1], item.upper_bound};
		cst      = {item.cost_coefficient[ValW-1], item.cost_coefficient};
		neg_cost = -cst;
		gap      = lo - up;
		inf_p    = {2'b00, cfg.infinity};
		inf_n    = -inf_p;
		ptol_p   = {2'b00, cfg.primal_tol};
		ptol_n   = -ptol_p;
		dtol_p   = {2'b00, cfg.dual_tol};
		dtol_n   = -dtol_p;
		dual     = cfg.maximize ? clamp_s48(neg_cost) : item.cost_coefficient;
		dual_w   = {dual[ValW-1], dual};
		ndual    = -dual_w;
		adual    = clamp_u47(dual_w[ValW] ? ndual : dual_w);
		lo_minf  = lo <= inf_n;
		lo_pinf  = lo >= inf_p;
		up_pinf  = up >= inf_p;
		up_minf  = up <= inf_n;
	end

	// Pick the bound and grade the item
	always_comb begin
		cls            = '0;
		cls.is_col     = item.operation == OP_COLUMN;
		cls.final_item = item.final_item;
		cls.status     = BASIS_BASIC;
		if (item.operation == OP_ROW) begin
			if (lo > ptol_p)
				cls.pinf = clamp_u47(lo);
			else if (up < ptol_n)
				cls.pinf = clamp_u47(-up);
		end else begin
			cls.cost = item.cost_coefficient;
			if (gap > 0) begin
				if (lo_pinf && up_minf) begin
					cls.status = BASIS_ZERO;
					cls.pinf   = MAX47;
					cls.dinf   = adual;
				end else if (lo_pinf) begin
					cls.value  = item.upper_bound;
					cls.status = BASIS_UPPER;
					cls.pinf   = clamp_u47(gap);
					cls.dinf   = clamp_u47(dual_w);
				end else begin
					cls.value  = item.lower_bound;
					cls.status = BASIS_LOWER;
					cls.pinf   = clamp_u47(gap);
					cls.dinf   = clamp_u47(ndual);
				end
			end else if (lo_minf && up_pinf) begin
				cls.status = BASIS_ZERO;
				cls.dinf   = adual;
			end else if (dual_w >= dtol_p) begin
				if (!lo_minf) begin
					cls.value  = item.lower_bound;
					cls.status = BASIS_LOWER;
				end else begin
					cls.value  = item.upper_bound;
					cls.status = BASIS_UPPER;
					cls.dinf   = clamp_u47(dual_w);
				end
			end else if (dual_w <= dtol_n) begin
				if (!up_pinf) begin
					cls.value  = item.upper_bound;
					cls.status = BASIS_UPPER;
				end else begin
					cls.value  = item.lower_bound;
					cls.status = BASIS_LOWER;
					cls.dinf   = clamp_u47(ndual);
				end
			end else begin
				if (lo_minf) begin
					cls.value  = item.upper_bound;
					cls.status = BASIS_UPPER;
				end else begin
					cls.value  = item.lower_bound;
					cls.status = BASIS_LOWER;
				end
				cls.dinf = adual;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ulpbs_product.sv =====
// Objective term value*cost in Q24.24: four 24x24 partial products, then
// combine, truncate and saturate. Two register stages; uses ulpbs_pkg.
`default_nettype none

module ulpbs_product
	import ulpbs_pkg::*;
(
	input  logic                   clk,
	input  logic                   en_s3,
	input  logic                   en_s4,
	input  logic signed [ValW-1:0] value,
	input  logic signed [ValW-1:0] cost,
	output logic signed [ValW-1:0] term_s4
);

	localparam int unsigned HalfW = ValW / 2;

	logic [ValW-1:0]        mag_a, mag_b;
	logic [ValW-1:0]        pp_ll_s3, pp_lh_s3, pp_hl_s3, pp_hh_s3;
	logic                   neg_s3;
	logic [ValW:0]          mid;
	logic [2*ValW-1:0]      prod;
	logic                   sat;
	logic [MagW-1:0]        mag_q;
	logic signed [ValW-1:0] term;

	// Operand magnitudes
	assign mag_a = value[ValW-1] ? ValW'(-value) : ValW'(value);
	assign mag_b = cost[ValW-1] ? ValW'(-cost) : ValW'(cost);

	// Register partial products
	always_ff @(posedge clk) begin
		if (en_s3) begin
			pp_ll_s3 <= mag_a[HalfW-1:0] * mag_b[HalfW-1:0];
			pp_lh_s3 <= mag_a[HalfW-1:0] * mag_b[ValW-1:HalfW];
			pp_hl_s3 <= mag_a[ValW-1:HalfW] * mag_b[HalfW-1:0];
			pp_hh_s3 <= mag_a[ValW-1:HalfW] * mag_b[ValW-1:HalfW];
			neg_s3   <= value[ValW-1] != cost[ValW-1];
		end
	end

	// Combine, drop 24 fraction bits, saturate
	always_comb begin
		mid   = {1'b0, pp_lh_s3} + {1'b0, pp_hl_s3};
		prod  = {pp_hh_s3, {ValW{1'b0}}}
		      + {{(HalfW-1){1'b0}}, mid, {HalfW{1'b0}}}
		      + {{ValW{1'b0}}, pp_ll_s3};
		sat   = |prod[2*ValW-1:MagW+HalfW];
		mag_q = prod[MagW+HalfW-1:HalfW];
		if (sat)
			term = neg_s3 ? MIN_S48 : MAX_S48;
		else if (neg_s3)
			term = -$signed({1'b0, mag_q});
		else
			term = $signed({1'b0, mag_q});
	end

	always_ff @(posedge clk) begin
		if (en_s4)
			term_s4 <= term;
	end

endmodule

`default_nettype wire

// ===== rtl/core/ulpbs_accum.sv =====
// Running counts, saturating sums, maxima and objective; builds the summary
// on the final item and clears. Uses ulpbs_pkg.
`default_nettype none

module ulpbs_accum
	import ulpbs_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd,
	input  class_t                 cls,
	input  logic signed [ValW-1:0] term,
	input  cfg_t                   cfg,
	input  logic                   offset_wr,
	input  logic signed [ValW-1:0] offset_data,
	output summary_t               summary
);

	localparam logic [CntW-1:0] CountCap =
		(MAX_ITEMS < 131071) ? CntW'(MAX_ITEMS) : {CntW{1'b1}};

	logic [CntW-1:0]        pcount_q, dcount_q, pcount_n, dcount_n;
	logic [MagW-1:0]        psum_q, dsum_q, pmax_q, dmax_q;
	logic [MagW-1:0]        psum_n, dsum_n, pmax_n, dmax_n;
	logic [ValW-1:0]        psum_w, dsum_w;
	logic signed [ValW-1:0] obj_q, obj_n;

	// Next accumulator values with this item folded in
	always_comb begin
		pcount_n = pcount_q;
		dcount_n = dcount_q;
		dsum_n   = dsum_q;
		dmax_n   = dmax_q;
		obj_n    = obj_q;
		if (cls.pinf > cfg.primal_tol && pcount_q < CountCap)
			pcount_n = pcount_q + 1'b1;
		psum_w = {1'b0, psum_q} + {1'b0, cls.pinf};
		psum_n = psum_w[MagW] ? MAX47 : psum_w[MagW-1:0];
		pmax_n = (cls.pinf > pmax_q) ? cls.pinf : pmax_q;
		dsum_w = {1'b0, dsum_q} + {1'b0, cls.dinf};
		if (cls.is_col) begin
			if (cls.dinf > cfg.dual_tol && dcount_q < CountCap)
				dcount_n = dcount_q + 1'b1;
			dsum_n = dsum_w[MagW] ? MAX47 : dsum_w[MagW-1:0];
			dmax_n = (cls.dinf > dmax_q) ? cls.dinf : dmax_q;
			obj_n  = clamp_s48({obj_q[ValW-1], obj_q} + {term[ValW-1], term});
		end
	end

	// Summary for the final item, zero otherwise
	always_comb begin
		summary = '0;
		if (cls.final_item) begin
			summary.valid = 1'b1;
			if (pcount_n != '0)
				summary.problem_status = MODEL_INFEASIBLE;
			else if (dcount_n != '0)
				summary.problem_status = MODEL_UNBOUNDED;
			else
				summary.problem_status = MODEL_OPTIMAL;
			summary.pcount    = pcount_n;
			summary.dcount    = dcount_n;
			summary.objective = obj_n;
			summary.pmax      = pmax_n;
			summary.dmax      = dmax_n;
			summary.psum      = psum_n;
			summary.dsum      = dsum_n;
		end
	end

	// Advance on each transfer to the output; clear after the final item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			dcount_q <= '0;
			psum_q   <= '0;
			dsum_q   <= '0;
			pmax_q   <= '0;
			dmax_q   <= '0;
			obj_q    <= '0;
		end else if (offset_wr) begin
			obj_q <= offset_data;
		end else if (upd) begin
			if (cls.final_item) begin
				pcount_q <= '0;
				dcount_q <= '0;
				psum_q   <= '0;
				dsum_q   <= '0;
				pmax_q   <= '0;
				dmax_q   <= '0;
				obj_q    <= cfg.offset;
			end else begin
				pcount_q <= pcount_n;
				dcount_q <= dcount_n;
				psum_q   <= psum_n;
				dsum_q   <= dsum_n;
				pmax_q   <= pmax_n;
				dmax_q   <= dmax_n;
				obj_q    <= obj_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/unconstrained_lp_bound_solver_unit.sv =====
// Unconstrained LP bound solver, top level. Uses ulpbs_pkg, ulpbs_classify,
// ulpbs_product and ulpbs_accum.
// Pipeline: a result passes the input register, classify, partial products,
// combine and accumulate into output, in that order.
// Throughput: one item per cycle; a stage holds only while the next one holds.
// Reset: empties all stages, clears the accumulators, loads config defaults.
`default_nettype none

module unconstrained_lp_bound_solver_unit
	import ulpbs_pkg::*;
#(
	parameter int unsigned MAX_ITEMS = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [ValW-1:0]        cfg_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic signed [ValW-1:0] lower_bound,
	input  logic signed [ValW-1:0] upper_bound,
	input  logic signed [ValW-1:0] cost_coefficient,
	input  logic                   final_item,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [ValW-1:0] primal_value,
	output logic signed [ValW-1:0] dual_value,
	output logic [1:0]             basis_status,
	output logic                   summary_valid,
	output logic [1:0]             problem_status,
	output logic [CntW-1:0]        primal_infeasible_count,
	output logic [CntW-1:0]        dual_infeasible_count,
	output logic signed [ValW-1:0] objective_value,
	output logic [MagW-1:0]        peak_primal_infeasibility,
	output logic [MagW-1:0]        peak_dual_infeasibility,
	output logic [MagW-1:0]        sum_primal_infeasibility,
	output logic [MagW-1:0]        sum_dual_infeasibility
);

	cfg_t     cfg_q;
	item_t    item_s1;
	class_t   cls, cls_s2, cls_s3, cls_s4;
	summary_t summary;
	logic     v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic     in_xfer, cfg_xfer, adv2, adv3, adv4, out_load;
	logic     offset_wr;
	logic signed [ValW-1:0] term_s4;

	// Stage handshake: a stage loads when the one after it frees up
	assign out_load  = v_s4 && (!out_valid_q || out_ready);
	assign adv4      = v_s3 && (!v_s4 || out_load);
	assign adv3      = v_s2 && (!v_s3 || adv4);
	assign adv2      = v_s1 && (!v_s2 || adv3);
	assign in_ready  = !v_s1 || adv2;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign offset_wr = cfg_xfer && cfg_index == CFG_OFFSET;
	assign out_valid = out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.primal_tol <= MagW'(2);
			cfg_q.dual_tol   <= MagW'(2);
			cfg_q.maximize   <= 1'b0;
			cfg_q.offset     <= '0;
			cfg_q.infinity   <= MAX47;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				CFG_PRIMAL_TOL: cfg_q.primal_tol <= cfg_data[MagW-1:0];
				CFG_DUAL_TOL:   cfg_q.dual_tol   <= cfg_data[MagW-1:0];
				CFG_SENSE:      cfg_q.maximize   <= cfg_data[1];
				CFG_OFFSET:     cfg_q.offset     <= $signed(cfg_data);
				CFG_INFINITY:   cfg_q.infinity   <= cfg_data[MagW-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer)
				v_s1 <= 1'b1;
			else if (adv2)
				v_s1 <= 1'b0;
			if (adv2)
				v_s2 <= 1'b1;
			else if (adv3)
				v_s2 <= 1'b0;
			if (adv3)
				v_s3 <= 1'b1;
			else if (adv4)
				v_s3 <= 1'b0;
			if (adv4)
				v_s4 <= 1'b1;
			else if (out_load)
				v_s4 <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.operation        <= operation;
			item_s1.lower_bound      <= lower_bound;
			item_s1.upper_bound      <= upper_bound;
			item_s1.cost_coefficient <= cost_coefficient;
			item_s1.final_item       <= final_item;
		end
		if (adv2)
			cls_s2 <= cls;
		if (adv3)
			cls_s3 <= cls_s2;
		if (adv4)
			cls_s4 <= cls_s3;
	end

	ulpbs_classify u_classify (
		.item (item_s1),
		.cfg  (cfg_q),
		.cls  (cls)
	);

	ulpbs_product u_product (
		.clk     (clk),
		.en_s3   (adv3),
		.en_s4   (adv4),
		.value   (cls_s2.value),
		.cost    (cls_s2.cost),
		.term_s4 (term_s4)
	);

	ulpbs_accum #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (out_load),
		.cls         (cls_s4),
		.term        (term_s4),
		.cfg         (cfg_q),
		.offset_wr   (offset_wr),
		.offset_data ($signed(cfg_data)),
		.summary     (summary)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			primal_value              <= cls_s4.value;
			dual_value                <= cls_s4.cost;
			basis_status              <= cls_s4.status;
			summary_valid             <= summary.valid;
			problem_status            <= summary.problem_status;
			primal_infeasible_count   <= summary.pcount;
			dual_infeasible_count     <= summary.dcount;
			objective_value           <= summary.objective;
			peak_primal_infeasibility <= summary.pmax;
			peak_dual_infeasibility   <= summary.dmax;
			sum_primal_infeasibility  <= summary.psum;
			sum_dual_infeasibility    <= summary.dsum;
		end
	end

	// Summary fields stay zero outside the final result
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !summary_valid |->
			primal_infeasible_count == '0 && dual_infeasible_count == '0 &&
			objective_value == '0 && sum_primal_infeasibility == '0)
		else $error("summary fields set on a non-final result");

	// Rows report a basic zero with zero dual
	a_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && basis_status == BASIS_BASIC |->
			primal_value == '0 && dual_value == '0)
		else $error("row result carries a value or dual");

	// Model status is infeasible exactly when the primal count is nonzero
	a_model_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && summary_valid |->
			(problem_status == MODEL_INFEASIBLE) == (primal_infeasible_count != '0))
		else $error("model status disagrees with primal count");

	// An item in the last stage leaves only into the output register
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !out_load |=> v_s4)
		else $error("item dropped from the accumulate stage");

	// Input side stays open while the first stage is empty
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

endmodule

`default_nettype wire
